/* src/pzdd_pkg.sv */
// Package for the packed zigzag delta decoder: parser phases, codes and helpers.
package pzdd_pkg;

  // Default width of the length counter.
  localparam int unsigned DefaultLengthBits = 32;

  // Widths of the message word and of a decoded value.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 64;

  // Wire types that the parser understands.
  localparam logic [2:0] WireVarint = 3'd0;
  localparam logic [2:0] WireLength = 3'd2;

  // Field numbers with a meaning of their own.
  localparam logic [4:0] FieldSeed  = 5'd3;
  localparam logic [4:0] FieldRunA  = 5'd4;
  localparam logic [4:0] FieldRunB  = 5'd5;

  // Varint shift bookkeeping: payload bits stop at 64, the count stops at 70.
  localparam logic [6:0] ShiftStep  = 7'd7;
  localparam logic [6:0] ShiftBits  = 7'd64;
  localparam logic [6:0] ShiftLimit = 7'd70;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_VARINT = 3'd1,
    PH_LEN    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_RUN    = 3'd4
  } phase_e;

  // Zigzag decode of a 64-bit value.
  function automatic logic [ValueW-1:0] unzig(input logic [ValueW-1:0] v);
    unzig = (v >> 1) ^ {ValueW{v[0]}};
  endfunction

  // True for the field numbers that carry a packed run.
  function automatic logic is_run_field(input logic [4:0] fnum);
    is_run_field = (fnum == FieldRunA) || (fnum == FieldRunB);
  endfunction

endpackage

/* src/packed_zigzag_delta_decoder.sv */
// Top level of the packed zigzag delta decoder: byte parser and output queue.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  input   | in        | in_valid_i / in_stall_o | msg_byte_i, end_of_msg_i
//  output  | out       | out_valid_o/out_stall_i | sample_o, last_sample_o
//
// One input word is taken every cycle while the output queue is not full; the
// parser state and the running sum are updated in the same cycle through one
// 64-bit add and a barrel shift. Results are registered into a two-entry output
// queue whose head drives the output, so input stalls only while it is full.
// Reset returns the parser to the tag phase with all sums and the seed at zero.
module packed_zigzag_delta_decoder #(
  parameter int unsigned LENGTH_BITS = pzdd_pkg::DefaultLengthBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [pzdd_pkg::ByteW-1:0]            msg_byte_i,
  input  logic                                  end_of_msg_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pzdd_pkg::ValueW-1:0]    sample_o,
  output logic                                  last_sample_o
);
  import pzdd_pkg::*;

  localparam logic [ValueW-1:0] MaxLen = {ValueW{1'b1}} >> (ValueW - LENGTH_BITS);

  // Parser state.
  phase_e                  phase_q, phase_d;
  logic [4:0]              field_q, field_d;
  logic [ValueW-1:0]       acc_q, acc_d;
  logic [6:0]              shift_q, shift_d;
  logic [LENGTH_BITS-1:0]  left_q, left_d;
  logic [ValueW-1:0]       seed_q, seed_d;
  logic [ValueW-1:0]       sum_q, sum_d;
  logic                    taken_q, taken_d;
  logic                    halted_q, halted_d;

  // Result of the current word.
  logic                    emit;
  logic [ValueW-1:0]       emit_val;
  logic                    emit_last;

  // Helper values.
  logic                    accept;
  logic                    more;
  logic [ValueW-1:0]       acc_gather;
  logic [6:0]              shift_gather;
  logic [ValueW-1:0]       len_sat;
  logic [LENGTH_BITS-1:0]  len;
  logic [LENGTH_BITS-1:0]  left_dec;
  logic [ValueW-1:0]       sum_add;

  // Output queue.
  logic [1:0]              count_q;
  logic [ValueW-1:0]       head_val_q, tail_val_q;
  logic                    head_last_q, tail_last_q;
  logic                    push, pop;

  assign accept = in_valid_i && !in_stall_o;
  assign more   = msg_byte_i[7];

  // Gather seven payload bits into the varint accumulator.
  always_comb begin
    acc_gather = acc_q;
    if (shift_q < ShiftBits) begin
      acc_gather = acc_q | ({{(ValueW-7){1'b0}}, msg_byte_i[6:0]} << shift_q[5:0]);
    end
    shift_gather = (shift_q < ShiftLimit) ? shift_q + ShiftStep : shift_q;
  end

  // Length with saturation, remaining count and the delta sum.
  assign len_sat  = (acc_gather > MaxLen) ? MaxLen : acc_gather;
  assign len      = len_sat[LENGTH_BITS-1:0];
  assign left_dec = (left_q != '0) ? left_q - LENGTH_BITS'(1) : left_q;
  assign sum_add  = sum_q + unzig(acc_gather);

  // Next state of the parser and the result of this word.
  always_comb begin
    phase_d   = phase_q;
    field_d   = field_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    left_d    = left_q;
    seed_d    = seed_q;
    sum_d     = sum_q;
    taken_d   = taken_q;
    halted_d  = halted_q;
    emit      = 1'b0;
    emit_val  = seed_q;
    emit_last = 1'b0;

    if (!halted_q) begin
      case (phase_q)
        PH_VARINT: begin
          acc_d   = acc_gather;
          shift_d = shift_gather;
          if (!more || end_of_msg_i) begin
            if (field_q == FieldSeed) begin
              seed_d = unzig(acc_gather);
            end
            acc_d   = '0;
            shift_d = '0;
            phase_d = PH_TAG;
          end
        end
        PH_LEN: begin
          acc_d   = acc_gather;
          shift_d = shift_gather;
          if (!more || end_of_msg_i) begin
            acc_d   = '0;
            shift_d = '0;
            left_d  = len;
            if (is_run_field(field_q) && !taken_q) begin
              taken_d   = 1'b1;
              sum_d     = seed_q;
              emit      = 1'b1;
              emit_val  = seed_q;
              emit_last = (len == '0) || end_of_msg_i;
              phase_d   = (len == '0) ? PH_TAG : PH_RUN;
            end else begin
              phase_d   = (len == '0) ? PH_TAG : PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_TAG;
          end
        end
        PH_RUN: begin
          left_d  = left_dec;
          acc_d   = acc_gather;
          shift_d = shift_gather;
          if (!more || (left_dec == '0) || end_of_msg_i) begin
            sum_d     = sum_add;
            acc_d     = '0;
            shift_d   = '0;
            emit      = 1'b1;
            emit_val  = sum_add;
            emit_last = (left_dec == '0) || end_of_msg_i;
            if (left_dec == '0) begin
              phase_d = PH_TAG;
            end
          end
        end
        default: begin
          field_d = msg_byte_i[7:3];
          acc_d   = '0;
          shift_d = '0;
          if (msg_byte_i[2:0] == WireVarint) begin
            phase_d = PH_VARINT;
          end else if (msg_byte_i[2:0] == WireLength) begin
            phase_d = PH_LEN;
            if (end_of_msg_i && is_run_field(msg_byte_i[7:3]) && !taken_q) begin
              taken_d   = 1'b1;
              sum_d     = seed_q;
              emit      = 1'b1;
              emit_val  = seed_q;
              emit_last = 1'b1;
            end
          end else begin
            phase_d  = PH_TAG;
            halted_d = 1'b1;
          end
        end
      endcase
    end

    // The final word of a message puts the parser back to its reset state.
    if (end_of_msg_i) begin
      phase_d  = PH_TAG;
      field_d  = '0;
      acc_d    = '0;
      shift_d  = '0;
      left_d   = '0;
      seed_d   = '0;
      sum_d    = '0;
      taken_d  = 1'b0;
      halted_d = 1'b0;
    end
  end

  // Parser registers, updated on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      field_q  <= '0;
      acc_q    <= '0;
      shift_q  <= '0;
      left_q   <= '0;
      seed_q   <= '0;
      sum_q    <= '0;
      taken_q  <= 1'b0;
      halted_q <= 1'b0;
    end else if (accept) begin
      phase_q  <= phase_d;
      field_q  <= field_d;
      acc_q    <= acc_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      seed_q   <= seed_d;
      sum_q    <= sum_d;
      taken_q  <= taken_d;
      halted_q <= halted_d;
    end
  end

  // Two-entry output queue; the head drives the output port.
  assign push        = accept && emit;
  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != 2'd0);
  assign in_stall_o  = (count_q == 2'd2);
  assign sample_o    = head_val_q;
  assign last_sample_o = head_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (count_q == 2'd2)) begin
      head_val_q  <= tail_val_q;
      head_last_q <= tail_last_q;
    end else if (push && ((count_q == 2'd0) || pop)) begin
      head_val_q  <= emit_val;
      head_last_q <= emit_last;
    end
    if (push && (count_q == 2'd1) && !pop) begin
      tail_val_q  <= emit_val;
      tail_last_q <= emit_last;
    end
  end

  // The queue never holds more than two words.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("output queue count out of range");

  // A halted parser sits in the tag phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |-> phase_q == PH_TAG)
    else $error("halted parser left the tag phase");

  // A run in progress was claimed and still has bytes to go.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RUN |-> (taken_q && (left_q != '0)))
    else $error("run phase without a claimed run or bytes left");

  // After the final word of a message the parser is back at its start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_msg_i) |=> (phase_q == PH_TAG && !taken_q && !halted_q
                                  && seed_q == '0))
    else $error("parser not cleared at message end");

endmodule
